[rtl/modexp_pkg.sv]
`default_nettype none

package modexp_pkg;

  localparam int DEF_EXP_WIDTH = 63;
  localparam int DEF_MOD_WIDTH = 31;
  localparam int PC_W          = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT_IN,
    OP_MUL,
    OP_CLR,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    ASEL_ONE,
    ASEL_SQ,
    ASEL_ACC
  } asel_t;

  typedef enum logic {
    BSEL_ONE,
    BSEL_SQ
  } bsel_t;

  typedef enum logic {
    DST_ACC,
    DST_SQ
  } dst_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_MZERO,
    C_EZERO,
    C_EBIT_CLR
  } cond_t;

  typedef struct packed {
    op_t   op;
    asel_t asel;
    bsel_t bsel;
    dst_t  dst;
    logic  shift;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic  in_ready;
    logic  red_start;
    asel_t asel;
    bsel_t bsel;
    logic  wr_acc;
    logic  wr_sq;
    logic  clr_acc;
    logic  shift_e;
    logic  emit;
  } cmd_t;

  // Flags from the datapath back to the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic red_done;
    logic m_zero;
    logic e_zero;
    logic e_bit0;
  } stat_t;

  // Program labels
  localparam pc_t L_FETCH   = 4'd0;
  localparam pc_t L_CHKM    = 4'd1;
  localparam pc_t L_INITACC = 4'd2;
  localparam pc_t L_INITSQ  = 4'd3;
  localparam pc_t L_LOOP    = 4'd4;
  localparam pc_t L_TEST    = 4'd5;
  localparam pc_t L_MULACC  = 4'd6;
  localparam pc_t L_SQUARE  = 4'd7;
  localparam pc_t L_ZERO    = 4'd8;
  localparam pc_t L_EMIT    = 4'd9;

  function automatic uword_t mk_word(op_t op, asel_t asel, bsel_t bsel, dst_t dst,
                                     logic shift, cond_t cond, pc_t target);
    uword_t w;
    w.op     = op;
    w.asel   = asel;
    w.bsel   = bsel;
    w.dst    = dst;
    w.shift  = shift;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Square-and-multiply program, exponent scanned LSB first
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      L_FETCH:   w = mk_word(OP_WAIT_IN, ASEL_ONE, BSEL_ONE, DST_ACC, 1'b0, C_NEVER, L_FETCH);
      L_CHKM:    w = mk_word(OP_NOP, ASEL_ONE, BSEL_ONE, DST_ACC, 1'b0, C_MZERO, L_ZERO);
      L_INITACC: w = mk_word(OP_MUL, ASEL_ONE, BSEL_ONE, DST_ACC, 1'b0, C_NEVER, L_FETCH);
      L_INITSQ:  w = mk_word(OP_MUL, ASEL_SQ, BSEL_ONE, DST_SQ, 1'b0, C_NEVER, L_FETCH);
      L_LOOP:    w = mk_word(OP_NOP, ASEL_ONE, BSEL_ONE, DST_ACC, 1'b0, C_EZERO, L_EMIT);
      L_TEST:    w = mk_word(OP_NOP, ASEL_ONE, BSEL_ONE, DST_ACC, 1'b0, C_EBIT_CLR, L_SQUARE);
      L_MULACC:  w = mk_word(OP_MUL, ASEL_ACC, BSEL_SQ, DST_ACC, 1'b0, C_NEVER, L_FETCH);
      L_SQUARE:  w = mk_word(OP_MUL, ASEL_SQ, BSEL_SQ, DST_SQ, 1'b1, C_ALWAYS, L_LOOP);
      L_ZERO:    w = mk_word(OP_CLR, ASEL_ONE, BSEL_ONE, DST_ACC, 1'b0, C_NEVER, L_FETCH);
      L_EMIT:    w = mk_word(OP_EMIT, ASEL_ONE, BSEL_ONE, DST_ACC, 1'b0, C_ALWAYS, L_FETCH);
      default:   w = mk_word(OP_NOP, ASEL_ONE, BSEL_ONE, DST_ACC, 1'b0, C_ALWAYS, L_FETCH);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/modexp_if.sv]
`default_nettype none

interface modexp_in_if
  import modexp_pkg::*;
#(
  parameter int EXP_WIDTH = DEF_EXP_WIDTH,
  parameter int MOD_WIDTH = DEF_MOD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] base;
  logic [EXP_WIDTH-1:0] exponent;
  logic [MOD_WIDTH-1:0] modulus;

  modport source (output valid, base, exponent, modulus, input ready);
  modport sink   (input valid, base, exponent, modulus, output ready);
endinterface

interface modexp_out_if
  import modexp_pkg::*;
#(
  parameter int MOD_WIDTH = DEF_MOD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] power_mod;

  modport source (output valid, power_mod, input ready);
  modport sink   (input valid, power_mod, output ready);
endinterface

`default_nettype wire

[rtl/modexp_mulred.sv]
`default_nettype none

// Modular multiplier: product registered at start, then shift-subtract
// reduction of two product bits per cycle.
module modexp_mulred
  import modexp_pkg::*;
#(
  parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [MOD_WIDTH-1:0] a,
  input  wire logic [MOD_WIDTH-1:0] b,
  input  wire logic [MOD_WIDTH-1:0] m,
  output logic                      done,
  output logic [MOD_WIDTH-1:0]      result
);

  localparam int PW    = 2 * MOD_WIDTH;
  localparam int CNT_W = $clog2(MOD_WIDTH + 1);

  logic [PW-1:0]        prod;
  logic [MOD_WIDTH-1:0] rem;
  logic [CNT_W-1:0]     cnt;

  logic [PW-1:0]        a_ext;
  logic [PW-1:0]        b_ext;
  logic [MOD_WIDTH:0]   m_ext;
  logic [MOD_WIDTH:0]   t1;
  logic [MOD_WIDTH:0]   r1;
  logic [MOD_WIDTH:0]   t2;
  logic [MOD_WIDTH:0]   r2;

  assign a_ext = {{MOD_WIDTH{1'b0}}, a};
  assign b_ext = {{MOD_WIDTH{1'b0}}, b};
  assign m_ext = {1'b0, m};

  // two restoring steps, top product bits first
  always_comb begin
    t1 = {rem, prod[PW-1]};
    r1 = (t1 >= m_ext) ? (t1 - m_ext) : t1;
    t2 = {r1[MOD_WIDTH-1:0], prod[PW-2]};
    r2 = (t2 >= m_ext) ? (t2 - m_ext) : t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod <= a_ext * b_ext;
        rem  <= '0;
        cnt  <= CNT_W'(MOD_WIDTH);
      end else if (cnt != '0) begin
        prod <= {prod[PW-3:0], 2'b00};
        rem  <= r2[MOD_WIDTH-1:0];
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  assign result = rem;

endmodule

`default_nettype wire

[rtl/modexp_useq.sv]
`default_nettype none

// Microcode sequencer: step counter, program table, conditional jumps.
module modexp_useq
  import modexp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  pc_t    pc;
  pc_t    pc_next;
  logic   issued;
  logic   issued_next;
  uword_t uw;
  logic   step_done;
  logic   jump;

  assign uw = ucode(pc);

  always_comb begin
    unique case (uw.op)
      OP_WAIT_IN: step_done = stat.in_valid;
      OP_MUL:     step_done = issued && stat.red_done;
      OP_EMIT:    step_done = stat.out_free;
      default:    step_done = 1'b1;
    endcase

    unique case (uw.cond)
      C_ALWAYS:   jump = 1'b1;
      C_MZERO:    jump = stat.m_zero;
      C_EZERO:    jump = stat.e_zero;
      C_EBIT_CLR: jump = !stat.e_bit0;
      default:    jump = 1'b0;
    endcase

    if (!step_done) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + 1'b1;
    end

    // launch the multiplier once per multiply step
    issued_next = issued;
    if (uw.op == OP_MUL && !issued) begin
      issued_next = 1'b1;
    end else if (step_done) begin
      issued_next = 1'b0;
    end

    cmd.in_ready  = (uw.op == OP_WAIT_IN);
    cmd.red_start = (uw.op == OP_MUL) && !issued;
    cmd.asel      = uw.asel;
    cmd.bsel      = uw.bsel;
    cmd.wr_acc    = (uw.op == OP_MUL) && step_done && (uw.dst == DST_ACC);
    cmd.wr_sq     = (uw.op == OP_MUL) && step_done && (uw.dst == DST_SQ);
    cmd.clr_acc   = (uw.op == OP_CLR);
    cmd.shift_e   = (uw.op == OP_MUL) && step_done && uw.shift;
    cmd.emit      = (uw.op == OP_EMIT) && step_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= L_FETCH;
      issued <= 1'b0;
    end else begin
      pc     <= pc_next;
      issued <= issued_next;
    end
  end

endmodule

`default_nettype wire

[rtl/modular_exponentiation.sv]
`default_nettype none

// Channel  Dir  Payload                          Transfer
// req      in   base, exponent, modulus          valid && ready
// rsp      out  power_mod                        valid && ready
//
// One item at a time. Each modular multiply runs on the shared
// two-bit-per-cycle reducer. An item with a nonzero modulus takes
// two multiplies, then one or two more per exponent bit up to the
// highest set one.
// Synchronous reset returns the sequencer to fetch and empties the output.
// The output register holds a result while rsp stalls; req is taken again
// meanwhile, and the next result waits at its emit step.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int EXP_WIDTH = DEF_EXP_WIDTH,
  parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
  input wire logic       clk,
  input wire logic       rst,
  modexp_in_if.sink      req,
  modexp_out_if.source   rsp
);

  cmd_t  cmd;
  stat_t stat;

  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] sq;
  logic [EXP_WIDTH-1:0] expo;
  logic [MOD_WIDTH-1:0] modv;
  logic [MOD_WIDTH-1:0] opa;
  logic [MOD_WIDTH-1:0] opb;
  logic [MOD_WIDTH-1:0] red_result;
  logic                 red_done;
  logic                 rsp_vld;
  logic [MOD_WIDTH-1:0] rsp_data;

  modexp_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  always_comb begin
    case (cmd.asel)
      ASEL_SQ:  opa = sq;
      ASEL_ACC: opa = acc;
      default:  opa = MOD_WIDTH'(1);
    endcase
    opb = (cmd.bsel == BSEL_SQ) ? sq : MOD_WIDTH'(1);
  end

  modexp_mulred #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_mulred (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.red_start),
    .a      (opa),
    .b      (opb),
    .m      (modv),
    .done   (red_done),
    .result (red_result)
  );

  assign stat.in_valid = req.valid;
  assign stat.out_free = !rsp_vld || rsp.ready;
  assign stat.red_done = red_done;
  assign stat.m_zero   = (modv == '0);
  assign stat.e_zero   = (expo == '0);
  assign stat.e_bit0   = expo[0];

  always_ff @(posedge clk) begin
    if (req.valid && cmd.in_ready) begin
      sq   <= req.base;
      expo <= req.exponent;
      modv <= req.modulus;
    end else begin
      if (cmd.wr_sq) begin
        sq <= red_result;
      end
      if (cmd.shift_e) begin
        expo <= expo >> 1;
      end
    end
    if (cmd.clr_acc) begin
      acc <= '0;
    end else if (cmd.wr_acc) begin
      acc <= red_result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (cmd.emit) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
    if (cmd.emit) begin
      rsp_data <= acc;
    end
  end

  // hold off req transfers while in reset
  assign req.ready     = cmd.in_ready && !rst;
  assign rsp.valid     = rsp_vld;
  assign rsp.power_mod = rsp_data;

endmodule

`default_nettype wire

[rtl/modexp_chk.sv]
`default_nettype none

module modexp_chk
  import modexp_pkg::*;
#(
  parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_valid,
  input wire logic                 req_ready,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic [MOD_WIDTH-1:0] power_mod
);

  logic [1:0] open_items;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // items taken in and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      open_items <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      open_items <= open_items + 1'b1;
    end else if (rsp_xfer && !req_xfer) begin
      open_items <= open_items - 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(power_mod))
    else $error("rsp payload changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> open_items != 2'd0)
    else $error("result shown with no item outstanding");

  a_one_ahead: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> open_items == 2'd0 || open_items == 2'd1)
    else $error("req ready with two items outstanding");

endmodule

bind modular_exponentiation modexp_chk #(
  .MOD_WIDTH (MOD_WIDTH)
) u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .power_mod (rsp.power_mod)
);

`default_nettype wire
